>>> rtl/svp_pkg.sv
// shared types and constants for the spatial volume and pan block
package svp_pkg;

  localparam int POS_W     = 30;
  localparam int DIFF_W    = 31;
  localparam int VEC_W     = 14;
  localparam int NEAR_W    = 30;
  localparam int FAR_W     = 31;
  localparam int VOL_W     = 8;
  localparam int SQ_W      = 62;
  localparam int SQR_W     = 61;
  localparam int PROD_W    = 45;
  localparam int DSUM_W    = 47;
  localparam int FRAC_BITS = 12;
  localparam int DOT_W     = DSUM_W - FRAC_BITS;
  localparam int ROOT_W    = 31;
  localparam int PAN_QB    = 13;
  localparam int VOL_QB    = 8;
  localparam int PAN_REM_W = DOT_W + FRAC_BITS;
  localparam int VOL_REM_W = VOL_W + FAR_W;

  localparam int PAN_CENTER = 128;
  localparam int PAN_GAIN   = 127;
  localparam int VAL_MAX    = 255;

  typedef struct packed {
    logic [SQ_W-1:0]        sq;
    logic signed [DOT_W-1:0] dot;
    logic [NEAR_W-1:0]      near_dist;
    logic [FAR_W-1:0]       far_dist;
    logic [VOL_W-1:0]       near_volume;
  } q_entry_t;

endpackage

>>> rtl/svp_front.sv
// front end: difference vector, squares, dot product and sum, two stages
module svp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [svp_pkg::POS_W-1:0]  src_x,
  input  logic signed [svp_pkg::POS_W-1:0]  src_y,
  input  logic signed [svp_pkg::POS_W-1:0]  src_z,
  input  logic signed [svp_pkg::POS_W-1:0]  lis_x,
  input  logic signed [svp_pkg::POS_W-1:0]  lis_y,
  input  logic signed [svp_pkg::POS_W-1:0]  lis_z,
  input  logic signed [svp_pkg::VEC_W-1:0]  right_x,
  input  logic signed [svp_pkg::VEC_W-1:0]  right_y,
  input  logic signed [svp_pkg::VEC_W-1:0]  right_z,
  input  logic [svp_pkg::NEAR_W-1:0]        near_dist,
  input  logic [svp_pkg::FAR_W-1:0]         far_dist,
  input  logic [svp_pkg::VOL_W-1:0]         near_volume,
  output logic                        push,
  output svp_pkg::q_entry_t           push_data,
  input  logic                        full
);
  import svp_pkg::*;

  logic                     a_valid;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [VEC_W-1:0]  rx, ry, rz;
  logic [NEAR_W-1:0]        a_near;
  logic [FAR_W-1:0]         a_far;
  logic [VOL_W-1:0]         a_ref;

  logic                     b_valid;
  logic [SQR_W-1:0]         sqx, sqy, sqz;
  logic signed [PROD_W-1:0] px, py, pz;
  logic [NEAR_W-1:0]        b_near;
  logic [FAR_W-1:0]         b_far;
  logic [VOL_W-1:0]         b_ref;

  logic                     adv;
  logic signed [DSUM_W-1:0] dsum;

  assign adv      = !b_valid || !full;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx     <= DIFF_W'(src_x) - DIFF_W'(lis_x);
      dy     <= DIFF_W'(src_y) - DIFF_W'(lis_y);
      dz     <= DIFF_W'(src_z) - DIFF_W'(lis_z);
      rx     <= right_x;
      ry     <= right_y;
      rz     <= right_z;
      a_near <= near_dist;
      a_far  <= far_dist;
      a_ref  <= near_volume;
      // squares are non-negative and below 2^61
      sqx    <= SQR_W'(dx * dx);
      sqy    <= SQR_W'(dy * dy);
      sqz    <= SQR_W'(dz * dz);
      px     <= PROD_W'(dx) * PROD_W'(rx);
      py     <= PROD_W'(dy) * PROD_W'(ry);
      pz     <= PROD_W'(dz) * PROD_W'(rz);
      b_near <= a_near;
      b_far  <= a_far;
      b_ref  <= a_ref;
    end
  end

  assign dsum = DSUM_W'(px) + DSUM_W'(py) + DSUM_W'(pz);

  assign push                  = b_valid && !full;
  assign push_data.sq          = SQ_W'(sqx) + SQ_W'(sqy) + SQ_W'(sqz);
  // upper bits give the floored shift
  assign push_data.dot         = dsum[DSUM_W-1:FRAC_BITS];
  assign push_data.near_dist   = b_near;
  assign push_data.far_dist    = b_far;
  assign push_data.near_volume = b_ref;

endmodule

>>> rtl/svp_queue.sv
// short word queue between front and back
module svp_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  svp_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output svp_pkg::q_entry_t pop_data,
  output logic              empty
);
  import svp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem [0:DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wr_ptr == rd_ptr)) else $error("pointers out of step");
`endif

endmodule

>>> rtl/svp_back.sv
// back end: pipelined square root, volume and pan dividers, output register
module svp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  svp_pkg::q_entry_t          pop_data,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [svp_pkg::VOL_W-1:0]  volume,
  output logic [svp_pkg::VOL_W-1:0]  pan
);
  import svp_pkg::*;

  localparam int OVF_Q = 1 << PAN_QB;

  typedef struct packed {
    logic [NEAR_W-1:0]       near_dist;
    logic [FAR_W-1:0]        far_dist;
    logic [VOL_W-1:0]        near_volume;
    logic signed [DOT_W-1:0] dot;
  } side_t;

  typedef struct packed {
    logic [PAN_REM_W-1:0] pan_rem;
    logic [PAN_QB-1:0]    pan_q;
    logic [VOL_REM_W-1:0] vol_rem;
    logic [VOL_QB-1:0]    vol_q;
    logic [ROOT_W-1:0]    len;
    logic [FAR_W-1:0]     vden;
    logic                 neg;
    logic                 ovf;
    logic                 zero;
    logic                 is_near;
    logic                 is_far;
    logic [VOL_W-1:0]     near_volume;
  } div_t;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty;

  // square root pipeline, one root bit per stage
  logic [SQ_W-1:0]   rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  side_t             side [0:ROOT_W];
  logic [ROOT_W:0]   sv;

  assign rem[0]  = pop_data.sq;
  assign root[0] = '0;
  assign side[0] = '{near_dist: pop_data.near_dist, far_dist: pop_data.far_dist,
                     near_volume: pop_data.near_volume, dot: pop_data.dot};
  assign sv[0]   = !empty;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [SQ_W:0] t;
    logic          take;
    assign t    = ((SQ_W + 1)'(root[k]) << (B + 1)) + ((SQ_W + 1)'(1) << (2 * B));
    assign take = {1'b0, rem[k]} >= t;
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= take ? SQ_W'({1'b0, rem[k]} - t) : rem[k];
        root[k+1] <= take ? (root[k] | (ROOT_W'(1) << B)) : root[k];
        side[k+1] <= side[k];
      end
    end
  end

  // classify and set up both divisions
  div_t              dv [0:PAN_QB];
  logic [PAN_QB:0]   dvv;
  logic [ROOT_W-1:0] len;
  side_t             sd;
  logic [DOT_W-1:0]  mag;

  assign len = root[ROOT_W];
  assign sd  = side[ROOT_W];
  assign mag = sd.dot[DOT_W-1] ? DOT_W'(-sd.dot) : DOT_W'(sd.dot);

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= sv[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].pan_rem     <= {mag, {FRAC_BITS{1'b0}}};
      dv[0].pan_q       <= '0;
      dv[0].vol_rem     <= VOL_REM_W'(sd.near_volume) * VOL_REM_W'(FAR_W'(sd.far_dist - len));
      dv[0].vol_q       <= '0;
      dv[0].len         <= len;
      dv[0].vden        <= FAR_W'(sd.far_dist - FAR_W'(sd.near_dist));
      dv[0].neg         <= sd.dot[DOT_W-1];
      // quotient would need more bits than the divider makes: pan saturates
      dv[0].ovf         <= {mag, {FRAC_BITS{1'b0}}} >=
                           (PAN_REM_W'(len) << PAN_QB);
      dv[0].zero        <= len == '0;
      dv[0].is_near     <= len <= ROOT_W'(sd.near_dist);
      dv[0].is_far      <= len >= sd.far_dist;
      dv[0].near_volume <= sd.near_volume;
    end
  end

  // restoring divide stages, pan every stage, volume in the last eight
  for (genvar s = 0; s < PAN_QB; s++) begin : g_div
    localparam int J = PAN_QB - 1 - s;
    logic [PAN_REM_W-1:0] pd;
    logic                 ptake;
    div_t                 nx;
    assign pd    = PAN_REM_W'(dv[s].len) << J;
    assign ptake = dv[s].pan_rem >= pd;
    always_comb begin
      nx = dv[s];
      if (ptake) begin
        nx.pan_rem = dv[s].pan_rem - pd;
        nx.pan_q   = dv[s].pan_q | (PAN_QB'(1) << J);
      end
      if (J < VOL_QB) begin
        if (dv[s].vol_rem >= (VOL_REM_W'(dv[s].vden) << J)) begin
          nx.vol_rem = dv[s].vol_rem - (VOL_REM_W'(dv[s].vden) << J);
          nx.vol_q   = dv[s].vol_q | (VOL_QB'(1) << J);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[s+1] <= 1'b0;
      end else if (adv) begin
        dvv[s+1] <= dvv[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[s+1] <= nx;
      end
    end
  end

  // pan mapping and output register
  div_t                    fl;
  logic [PAN_QB:0]         qm;
  logic signed [PAN_QB+1:0] qs;
  logic signed [PAN_QB+9:0] prod;
  logic signed [11:0]      pv;
  logic [VOL_W-1:0]        pan_next, volume_next;

  assign fl   = dv[PAN_QB];
  assign qm   = fl.ovf ? (PAN_QB + 1)'(OVF_Q) : {1'b0, fl.pan_q};
  assign qs   = fl.neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  assign prod = (PAN_QB + 10)'(qs) * (PAN_QB + 10)'(PAN_GAIN);
  assign pv   = 12'(prod >>> FRAC_BITS) + 12'(PAN_CENTER);

  always_comb begin
    if (fl.zero) begin
      pan_next = VOL_W'(PAN_CENTER);
    end else if (pv < 0) begin
      pan_next = '0;
    end else if (pv > 12'(VAL_MAX)) begin
      pan_next = VOL_W'(VAL_MAX);
    end else begin
      pan_next = pv[VOL_W-1:0];
    end
    if (fl.is_near) begin
      volume_next = fl.near_volume;
    end else if (fl.is_far) begin
      volume_next = '0;
    end else begin
      volume_next = fl.vol_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dvv[PAN_QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      volume <= volume_next;
      pan    <= pan_next;
    end
  end

endmodule

>>> rtl/spatial_audio_volume_pan.sv
// Volume and stereo pan of one sound source seen from a listener. The block takes one
// word per clock while in_ready is high and returns one result word per input word, in
// order. A word passes 49 registers: two front stages (difference, squares and dot
// products), the queue memory, 31 square root stages (one root bit each), a setup stage,
// 13 restoring divide stages that make the pan quotient, the last eight of them also the
// volume ratio, and the output register. The back pipeline advances whenever the output
// register is free or being taken; the front keeps filling the queue while the back is
// stalled, until the queue is full.
module spatial_audio_volume_pan #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [svp_pkg::POS_W-1:0]  src_x,
  input  logic signed [svp_pkg::POS_W-1:0]  src_y,
  input  logic signed [svp_pkg::POS_W-1:0]  src_z,
  input  logic signed [svp_pkg::POS_W-1:0]  lis_x,
  input  logic signed [svp_pkg::POS_W-1:0]  lis_y,
  input  logic signed [svp_pkg::POS_W-1:0]  lis_z,
  input  logic signed [svp_pkg::VEC_W-1:0]  right_x,
  input  logic signed [svp_pkg::VEC_W-1:0]  right_y,
  input  logic signed [svp_pkg::VEC_W-1:0]  right_z,
  input  logic [svp_pkg::NEAR_W-1:0]        near_dist,
  input  logic [svp_pkg::FAR_W-1:0]         far_dist,
  input  logic [svp_pkg::VOL_W-1:0]         near_volume,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [svp_pkg::VOL_W-1:0]         volume,
  output logic [svp_pkg::VOL_W-1:0]         pan
);
  import svp_pkg::*;

  logic     push, full, pop, empty;
  q_entry_t push_data, pop_data;

  svp_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .src_x, .src_y, .src_z, .lis_x, .lis_y, .lis_z,
    .right_x, .right_y, .right_z, .near_dist, .far_dist, .near_volume,
    .push, .push_data, .full
  );

  svp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .pop_data, .empty
  );

  svp_back u_back (
    .clk, .rst, .pop_data, .empty, .pop, .out_valid, .out_ready, .volume, .pan
  );

endmodule

>>> dv/tb_spatial_audio_volume_pan.sv
// testbench for the spatial volume and pan block: directed table, then random words
module tb_spatial_audio_volume_pan;
  import svp_pkg::*;

  localparam int N_RANDOM   = 1250;
  localparam int N_CALM     = 150;
  localparam int CYCLE_STOP = 400000;

  typedef struct {
    logic signed [POS_W-1:0] sx, sy, sz, lx, ly, lz;
    logic signed [VEC_W-1:0] rx, ry, rz;
    logic [NEAR_W-1:0]       nd;
    logic [FAR_W-1:0]        fd;
    logic [VOL_W-1:0]        rv;
    bit                      typed;
    logic [VOL_W-1:0]        tv, tp;
  } src_word_t;

  typedef struct {
    logic [VOL_W-1:0] v, p;
  } mix_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [POS_W-1:0] src_x = '0, src_y = '0, src_z = '0;
  logic signed [POS_W-1:0] lis_x = '0, lis_y = '0, lis_z = '0;
  logic signed [VEC_W-1:0] right_x = '0, right_y = '0, right_z = '0;
  logic [NEAR_W-1:0] near_dist = '0;
  logic [FAR_W-1:0]  far_dist = '0;
  logic [VOL_W-1:0]  near_volume = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [VOL_W-1:0] volume, pan;

  mix_t      mix_q[$];
  src_word_t rows[$];
  int        errors = 0;
  int        cycles = 0;
  int        hold = 0;
  bit        calm = 0;

  spatial_audio_volume_pan dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic mix_t predict_mix(input src_word_t w);
    longint dx, dy, dz, dot, q, pn;
    longint unsigned sq, d, vv, nd, fd;
    mix_t m;
    dx = longint'(w.sx) - longint'(w.lx);
    dy = longint'(w.sy) - longint'(w.ly);
    dz = longint'(w.sz) - longint'(w.lz);
    sq = dx * dx + dy * dy + dz * dz;
    d  = root_floor(sq);
    nd = w.nd;
    fd = w.fd;
    if (d <= nd) vv = w.rv;
    else if (d >= fd) vv = 0;
    else vv = (longint'(w.rv) * (fd - d)) / (fd - nd);
    if (vv > VAL_MAX) vv = VAL_MAX;
    if (d > 0) begin
      dot = (dx * longint'(w.rx) + dy * longint'(w.ry) + dz * longint'(w.rz)) >>> FRAC_BITS;
      q   = (dot * 4096) / longint'(d);
      pn  = PAN_CENTER + ((q * PAN_GAIN) >>> FRAC_BITS);
      if (pn < 0) pn = 0;
      if (pn > VAL_MAX) pn = VAL_MAX;
    end else begin
      pn = PAN_CENTER;
    end
    m.v = vv[VOL_W-1:0];
    m.p = pn[VOL_W-1:0];
    return m;
  endfunction

  task automatic fail_note(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic src_word_t mk(input longint sx, sy, sz, lx, ly, lz, rx, ry, rz,
                                   input longint nd, fd, rv, input bit typed = 0,
                                   input int tv = 0, input int tp = 0);
    src_word_t w;
    w.sx = POS_W'(sx); w.sy = POS_W'(sy); w.sz = POS_W'(sz);
    w.lx = POS_W'(lx); w.ly = POS_W'(ly); w.lz = POS_W'(lz);
    w.rx = VEC_W'(rx); w.ry = VEC_W'(ry); w.rz = VEC_W'(rz);
    w.nd = NEAR_W'(nd); w.fd = FAR_W'(fd); w.rv = VOL_W'(rv);
    w.typed = typed; w.tv = VOL_W'(tv); w.tp = VOL_W'(tp);
    return w;
  endfunction

  task automatic send_word(input src_word_t w);
    mix_t m;
    in_valid <= 1;
    src_x <= w.sx; src_y <= w.sy; src_z <= w.sz;
    lis_x <= w.lx; lis_y <= w.ly; lis_z <= w.lz;
    right_x <= w.rx; right_y <= w.ry; right_z <= w.rz;
    near_dist <= w.nd; far_dist <= w.fd; near_volume <= w.rv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.typed) begin
      m.v = w.tv;
      m.p = w.tp;
    end else begin
      m = predict_mix(w);
    end
    mix_q.push_back(m);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic src_word_t rand_word();
    src_word_t w;
    int mode;
    mode = $urandom_range(0, 9);
    w.sx = POS_W'($urandom); w.sy = POS_W'($urandom); w.sz = POS_W'($urandom);
    w.lx = POS_W'($urandom); w.ly = POS_W'($urandom); w.lz = POS_W'($urandom);
    w.rx = VEC_W'($urandom_range(0, 8192) - 4096);
    w.ry = VEC_W'($urandom_range(0, 8192) - 4096);
    w.rz = VEC_W'($urandom_range(0, 8192) - 4096);
    w.nd = NEAR_W'($urandom); w.fd = FAR_W'($urandom); w.rv = VOL_W'($urandom);
    w.typed = 0;
    if (mode == 0) begin
      // raw right vector bits, well outside unit length
      w.rx = VEC_W'($urandom); w.ry = VEC_W'($urandom); w.rz = VEC_W'($urandom);
    end else if (mode >= 3) begin
      // small offsets so the distance lands near the attenuation window
      w.sx = POS_W'(w.lx + ($urandom_range(0, 1 << 21) - (1 << 20)));
      w.sy = POS_W'(w.ly + ($urandom_range(0, 1 << 21) - (1 << 20)));
      w.sz = POS_W'(w.lz + ($urandom_range(0, 1 << 21) - (1 << 20)));
      if (mode == 3) begin
        w.sx = w.lx; w.sy = w.ly; w.sz = w.lz;
      end
      w.nd = NEAR_W'($urandom_range(0, 1 << 21));
      if (mode == 4) w.fd = FAR_W'($urandom_range(0, 1 << 21));
      else w.fd = FAR_W'(w.nd + $urandom_range(0, 1 << 22));
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1;
    end else if (hold > 0) begin
      hold <= hold - 1;
      out_ready <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      hold <= $urandom_range(0, 11);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // result checker
  always @(posedge clk) begin
    mix_t m;
    if (!rst && out_valid && out_ready) begin
      if (mix_q.size() == 0) begin
        fail_note($sformatf("result with nothing expected: vol %0d pan %0d", volume, pan));
      end else begin
        m = mix_q.pop_front();
        if (volume !== m.v) fail_note($sformatf("volume %0d, want %0d", volume, m.v));
        if (pan !== m.p) fail_note($sformatf("pan %0d, want %0d", pan, m.p));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_STOP) begin
      $display("timeout");
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 200, 1, 200, 128));
    rows.push_back(mk(4096, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 0, 255, 1, 0, 255));
    rows.push_back(mk(4096, 0, 0, 0, 0, 0, -4096, 0, 0, 0, 0, 255, 1, 0, 1));
    rows.push_back(mk(4096, 0, 0, 0, 0, 0, 0, 0, 0, 4096, 9999, 77, 1, 77, 128));
    rows.push_back(mk(536870911, 536870911, 536870911, -536870912, -536870912, -536870912,
                      8191, 8191, 8191, 1073741823, 2147483647, 255));
    rows.push_back(mk(-536870912, -536870912, -536870912, 536870911, 536870911, 536870911,
                      -8192, -8192, -8192, 0, 2147483647, 255));
    // near not below far
    rows.push_back(mk(8192, 0, 0, 0, 0, 0, 0, 0, 0, 8192, 100, 9, 1, 9, 128));
    rows.push_back(mk(8192, 0, 0, 0, 0, 0, 0, 0, 0, 8191, 100, 9, 1, 0, 128));
    rows.push_back(mk(8192, 0, 0, 0, 0, 0, 0, 0, 0, 4096, 12288, 200, 1, 100, 128));
    rows.push_back(mk(0, -4096, 0, 0, 0, 0, 0, 4096, 0, 0, 1 << 20, 128));
    rows.push_back(mk(4096, 0, 0, 0, 0, 0, 8191, 0, 0, 0, 1 << 20, 255));
    rows.push_back(mk(12345, -6789, 1000, -50, 70, -9000, 2896, -2896, 0, 3000, 60000, 180));
    rows.push_back(mk(-300000, 200000, 100000, 0, 0, 0, 0, 0, -4096, 1073741823, 0, 1));

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_word(rows[i]);
      sender_gap();
    end
    // hold off until the pipe has drained
    in_valid <= 0;
    while (mix_q.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) calm = 1;
      send_word(rand_word());
      sender_gap();
    end
    in_valid <= 0;
    while (mix_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
